FILE: rtl/ahdsr_pkg.sv
// ----------------------------------------------------------------------------
// ahdsr_pkg
// Shared widths, codes, types and helpers for the AHDSR envelope generator.
// ----------------------------------------------------------------------------
package ahdsr_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);

    localparam int LEVEL_W     = 16;
    localparam int COUNT_W     = 21;
    localparam int OP_W        = 3;
    localparam int SEL_W       = 2;
    localparam int IDX_W       = 12;
    localparam int PHASE_W     = 3;
    localparam int CFG_LEN_W   = 13;
    localparam int HOLD_W      = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = 2 * LEVEL_W;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'h8000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_GATE_ON  = 3'd1,
        OP_GATE_OFF = 3'd2,
        OP_STEAL    = 3'd3,
        OP_KILL     = 3'd4,
        OP_LOAD     = 3'd5
    } op_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_ATTACK  = 3'd0,
        PH_HOLD    = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4,
        PH_IDLE    = 3'd5
    } phase_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_ATTACK  = 2'd0,
        SEL_DECAY   = 2'd1,
        SEL_RELEASE = 2'd2
    } table_sel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_LEN  = 3'd0,
        CFG_HOLD_LEN    = 3'd1,
        CFG_DECAY_LEN   = 3'd2,
        CFG_RELEASE_LEN = 3'd3,
        CFG_SUSTAIN     = 3'd4,
        CFG_KILL_RECIP  = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [COUNT_W-1:0] a;
        logic [COUNT_W-1:0] b;
    } alu_req_t;

    // flag: carry out for add, borrow for subtract
    typedef struct packed {
        logic [PROD_W-1:0] res;
        logic              flag;
    } alu_rsp_t;

    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] len);
        if (int'(len) > TABLE_DEPTH)
            return LEN_W'(TABLE_DEPTH);
        else
            return LEN_W'(len);
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        return (v > FULL_LEVEL) ? FULL_LEVEL : v;
    endfunction

endpackage

FILE: rtl/ahdsr_ram.sv
// ----------------------------------------------------------------------------
// ahdsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ahdsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/ahdsr_alu.sv
// ----------------------------------------------------------------------------
// ahdsr_alu
// Shared arithmetic unit: add, subtract with borrow, 16x16 multiply.
// ----------------------------------------------------------------------------
module ahdsr_alu (
    input  ahdsr_pkg::alu_req_t req,
    output ahdsr_pkg::alu_rsp_t rsp
);
    import ahdsr_pkg::*;

    logic [COUNT_W:0] sum;

    always_comb
    begin
        sum = '0;
        rsp = '0;
        case (req.op)
            ALU_ADD:
            begin
                sum      = {1'b0, req.a} + {1'b0, req.b};
                rsp.res  = PROD_W'(sum[COUNT_W-1:0]);
                rsp.flag = sum[COUNT_W];
            end
            ALU_SUB:
            begin
                sum      = {1'b0, req.a} - {1'b0, req.b};
                rsp.res  = PROD_W'(sum[COUNT_W-1:0]);
                rsp.flag = sum[COUNT_W];
            end
            ALU_MUL:
            begin
                rsp.res  = PROD_W'(req.a[LEVEL_W-1:0]) * PROD_W'(req.b[LEVEL_W-1:0]);
                rsp.flag = 1'b0;
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end

endmodule

FILE: rtl/ahdsr_envelope_generator_core.sv
// ----------------------------------------------------------------------------
// ahdsr_envelope_generator_core
// Table-driven attack-hold-decay-sustain-release envelope with steal and
// quick-kill, built around one shared add/subtract/multiply unit.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready with operation, table_select,
//   table_index and table_value. Every request returns one result
//   (level, phase, killing) on out_valid/out_ready.
//   Registers are written through cfg_write/cfg_index/cfg_data; the user
//   must write them only while idle, which the core does not enforce.
//   in_ready is high only while the sequencer is idle; one request at a time.
//   Sequencer steps from accept to the result register (done = completion):
//     gate on, gate off, load, unused codes : done
//     kill quick                            : multiply, done
//     tick while killing / table-free phase : subtract, count, done
//     tick reading a curve table            : compare, read, count, done
//     steal : check, sum, midpoint, neighbour, reads and compares per
//             search step, at most 13 steps for a 4096-entry attack curve
//   A result waits in the output register while the receiver stalls; the
//   next request is still accepted, and its result is held back until the
//   register frees. Reset puts the envelope in idle at level zero with the
//   default registers; curve tables hold nothing until loaded.
// ----------------------------------------------------------------------------
module ahdsr_envelope_generator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ahdsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ahdsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ahdsr_pkg::OP_W-1:0]           operation,
    input  logic [ahdsr_pkg::SEL_W-1:0]          table_select,
    input  logic [ahdsr_pkg::IDX_W-1:0]          table_index,
    input  logic [ahdsr_pkg::LEVEL_W-1:0]        table_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ahdsr_pkg::LEVEL_W-1:0]        level,
    output logic [ahdsr_pkg::PHASE_W-1:0]        phase,
    output logic                                 killing
);
    import ahdsr_pkg::*;

    localparam logic [LEVEL_W-1:0] SUSTAIN_RESET    = 16'd16384;
    localparam logic [LEVEL_W-1:0] KILL_RECIP_RESET = 16'd331;

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_KSUB  = 18'h00002,
        S_PCMP  = 18'h00004,
        S_PREAD = 18'h00008,
        S_INC   = 18'h00010,
        S_MUL   = 18'h00020,
        S_SCHK  = 18'h00040,
        S_SSUM  = 18'h00080,
        S_SMID  = 18'h00100,
        S_SUP   = 18'h00200,
        S_SUPC  = 18'h00400,
        S_RDB   = 18'h00800,
        S_CA    = 18'h01000,
        S_CB    = 18'h02000,
        S_CD    = 18'h04000,
        S_SCLMP = 18'h08000,
        S_SLM1  = 18'h10000,
        S_DONE  = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_LEN_W-1:0] attack_len_reg, decay_len_reg, release_len_reg;
    logic [HOLD_W-1:0]    hold_len_reg;
    logic [LEVEL_W-1:0]   sustain_level_reg, kill_recip_reg;

    // envelope state
    phase_t               env_phase_reg, env_phase_next;
    logic [COUNT_W-1:0]   phase_count_reg, phase_count_next;
    logic [LEVEL_W-1:0]   out_level_reg, out_level_next;
    logic                 kill_active_reg, kill_active_next;
    logic [LEVEL_W-1:0]   kill_step_reg, kill_step_next;

    // result register
    logic [LEVEL_W-1:0]   res_level_reg, res_level_next;
    phase_t               res_phase_reg, res_phase_next;
    logic                 res_killing_reg, res_killing_next;
    logic                 out_valid_reg, out_valid_next;

    // search working registers
    logic [LEN_W-1:0]     left_reg, left_next;
    logic [LEN_W-1:0]     rend_reg, rend_next;
    logic [LEN_W:0]       sum_reg, sum_next;
    logic [ADDR_W-1:0]    mid_reg, mid_next;
    logic [LEN_W-1:0]     upraw_reg, upraw_next;
    logic [ADDR_W-1:0]    up_reg, up_next;
    logic [LEVEL_W-1:0]   a_reg, a_next;
    logic [LEVEL_W-1:0]   da_reg, da_next;
    logic [LEVEL_W-1:0]   db_reg, db_next;
    logic                 a_le_reg, a_le_next;
    logic                 a_lt_reg, a_lt_next;

    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;
    logic                 alu_zero;

    logic [LEN_W-1:0]     eff_attack, eff_decay, eff_release;
    logic [LEVEL_W-1:0]   sustain_eff;
    logic [COUNT_W-1:0]   len_cur;
    logic [LEVEL_W-1:0]   step_raw;
    logic                 b_gt;

    logic                 accept, idx_ok, load_req;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [LEVEL_W-1:0]   wr_data;
    logic                 atk_wr_en, dec_wr_en, rel_wr_en;
    logic                 atk_rd_en, dec_rd_en, rel_rd_en;
    logic [LEVEL_W-1:0]   atk_rd_data, dec_rd_data, rel_rd_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign level     = res_level_reg;
    assign phase     = res_phase_reg;
    assign killing   = res_killing_reg;

    assign eff_attack  = eff_len(attack_len_reg);
    assign eff_decay   = eff_len(decay_len_reg);
    assign eff_release = eff_len(release_len_reg);
    assign sustain_eff = clamp_level(sustain_level_reg);

    // table loads happen in the accept cycle
    assign idx_ok    = int'(table_index) < TABLE_DEPTH;
    assign load_req  = accept && (op_t'(operation) == OP_LOAD) && idx_ok;
    assign wr_addr   = ADDR_W'(table_index);
    assign wr_data   = clamp_level(table_value);
    assign atk_wr_en = load_req && (table_select == SEL_ATTACK);
    assign dec_wr_en = load_req && (table_select == SEL_DECAY);
    assign rel_wr_en = load_req && (table_select == SEL_RELEASE);

    ahdsr_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_attack_ram (
        .clk     (clk),
        .wr_en   (atk_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (atk_rd_en),
        .rd_addr (rd_addr),
        .rd_data (atk_rd_data)
    );

    ahdsr_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_decay_ram (
        .clk     (clk),
        .wr_en   (dec_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (dec_rd_en),
        .rd_addr (rd_addr),
        .rd_data (dec_rd_data)
    );

    ahdsr_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_release_ram (
        .clk     (clk),
        .wr_en   (rel_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rel_rd_en),
        .rd_addr (rd_addr),
        .rd_data (rel_rd_data)
    );

    ahdsr_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign alu_zero = (alu_rsp.res[COUNT_W-1:0] == '0);
    assign step_raw = alu_rsp.res[PROD_W-1:LEVEL_W];
    assign b_gt     = !alu_rsp.flag && !alu_zero;

    always_comb
    begin
        case (env_phase_reg)
            PH_ATTACK:  len_cur = COUNT_W'(eff_attack);
            PH_HOLD:    len_cur = COUNT_W'(hold_len_reg);
            PH_DECAY:   len_cur = COUNT_W'(eff_decay);
            PH_RELEASE: len_cur = COUNT_W'(eff_release);
            default:    len_cur = '0;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        env_phase_next   = env_phase_reg;
        phase_count_next = phase_count_reg;
        out_level_next   = out_level_reg;
        kill_active_next = kill_active_reg;
        kill_step_next   = kill_step_reg;
        res_level_next   = res_level_reg;
        res_phase_next   = res_phase_reg;
        res_killing_next = res_killing_reg;
        out_valid_next   = out_valid_reg;
        left_next        = left_reg;
        rend_next        = rend_reg;
        sum_next         = sum_reg;
        mid_next         = mid_reg;
        upraw_next       = upraw_reg;
        up_next          = up_reg;
        a_next           = a_reg;
        da_next          = da_reg;
        db_next          = db_reg;
        a_le_next        = a_le_reg;
        a_lt_next        = a_lt_reg;
        alu_req.op       = ALU_ADD;
        alu_req.a        = '0;
        alu_req.b        = '0;
        rd_addr          = '0;
        atk_rd_en        = 1'b0;
        dec_rd_en        = 1'b0;
        rel_rd_en        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_t'(operation))
                        OP_TICK:
                        begin
                            state_next = kill_active_reg ? S_KSUB : S_PCMP;
                        end
                        OP_GATE_ON:
                        begin
                            env_phase_next   = PH_ATTACK;
                            phase_count_next = '0;
                            kill_active_next = 1'b0;
                            state_next       = S_DONE;
                        end
                        OP_GATE_OFF:
                        begin
                            env_phase_next   = PH_RELEASE;
                            phase_count_next = '0;
                            state_next       = S_DONE;
                        end
                        OP_STEAL:
                        begin
                            env_phase_next   = PH_ATTACK;
                            kill_active_next = 1'b0;
                            left_next        = '0;
                            rend_next        = eff_attack;
                            if (eff_attack == '0)
                            begin
                                phase_count_next = '0;
                                state_next       = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCHK;
                            end
                        end
                        OP_KILL:
                        begin
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_KSUB:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = COUNT_W'(out_level_reg);
                alu_req.b  = COUNT_W'(kill_step_reg);
                if (alu_rsp.flag || alu_zero)
                begin
                    out_level_next   = '0;
                    kill_active_next = 1'b0;
                end
                else
                begin
                    out_level_next   = alu_rsp.res[LEVEL_W-1:0];
                    kill_active_next = 1'b1;
                end
                state_next = S_INC;
            end

            S_PCMP:
            begin
                // no borrow: count has reached the phase length
                alu_req.op = ALU_SUB;
                alu_req.a  = phase_count_reg;
                alu_req.b  = len_cur;
                rd_addr    = phase_count_reg[ADDR_W-1:0];
                state_next = S_INC;
                case (env_phase_reg)
                    PH_ATTACK:
                    begin
                        if (!alu_rsp.flag)
                        begin
                            env_phase_next   = PH_HOLD;
                            phase_count_next = '0;
                            out_level_next   = FULL_LEVEL;
                        end
                        else
                        begin
                            atk_rd_en  = 1'b1;
                            state_next = S_PREAD;
                        end
                    end
                    PH_HOLD:
                    begin
                        if (!alu_rsp.flag)
                        begin
                            env_phase_next   = PH_DECAY;
                            phase_count_next = '0;
                        end
                        out_level_next = FULL_LEVEL;
                    end
                    PH_DECAY:
                    begin
                        if (!alu_rsp.flag)
                        begin
                            env_phase_next   = PH_SUSTAIN;
                            phase_count_next = '0;
                            out_level_next   = sustain_eff;
                        end
                        else
                        begin
                            dec_rd_en  = 1'b1;
                            state_next = S_PREAD;
                        end
                    end
                    PH_SUSTAIN:
                    begin
                        out_level_next = sustain_eff;
                    end
                    PH_RELEASE:
                    begin
                        if (!alu_rsp.flag)
                        begin
                            env_phase_next   = PH_IDLE;
                            phase_count_next = '0;
                            out_level_next   = '0;
                        end
                        else
                        begin
                            rel_rd_en  = 1'b1;
                            state_next = S_PREAD;
                        end
                    end
                    default:
                    begin
                        out_level_next = '0;
                    end
                endcase
            end

            S_PREAD:
            begin
                case (env_phase_reg)
                    PH_ATTACK: out_level_next = atk_rd_data;
                    PH_DECAY:  out_level_next = dec_rd_data;
                    default:   out_level_next = rel_rd_data;
                endcase
                state_next = S_INC;
            end

            S_INC:
            begin
                // carry out means the count is already at its ceiling
                alu_req.op = ALU_ADD;
                alu_req.a  = phase_count_reg;
                alu_req.b  = COUNT_W'(1);
                if (!alu_rsp.flag)
                begin
                    phase_count_next = alu_rsp.res[COUNT_W-1:0];
                end
                state_next = S_DONE;
            end

            S_MUL:
            begin
                alu_req.op       = ALU_MUL;
                alu_req.a        = COUNT_W'(out_level_reg);
                alu_req.b        = COUNT_W'(kill_recip_reg);
                kill_active_next = 1'b1;
                if (step_raw == '0 && out_level_reg != '0)
                    kill_step_next = LEVEL_W'(1);
                else
                    kill_step_next = step_raw;
                state_next = S_DONE;
            end

            S_SCHK:
            begin
                // continue while left < right + 1
                alu_req.op = ALU_SUB;
                alu_req.a  = COUNT_W'(left_reg);
                alu_req.b  = COUNT_W'(rend_reg);
                state_next = alu_rsp.flag ? S_SSUM : S_SCLMP;
            end

            S_SSUM:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = COUNT_W'(left_reg);
                alu_req.b  = COUNT_W'(rend_reg);
                sum_next   = alu_rsp.res[LEN_W:0];
                state_next = S_SMID;
            end

            S_SMID:
            begin
                // mid = (left + right) / 2, right = rend - 1
                alu_req.op = ALU_SUB;
                alu_req.a  = COUNT_W'(sum_reg);
                alu_req.b  = COUNT_W'(1);
                mid_next   = alu_rsp.res[ADDR_W:1];
                state_next = S_SUP;
            end

            S_SUP:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = COUNT_W'(mid_reg);
                alu_req.b  = COUNT_W'(1);
                upraw_next = alu_rsp.res[LEN_W-1:0];
                atk_rd_en  = 1'b1;
                rd_addr    = mid_reg;
                state_next = S_SUPC;
            end

            S_SUPC:
            begin
                // upper neighbour clamps to the last entry
                alu_req.op = ALU_SUB;
                alu_req.a  = COUNT_W'(upraw_reg);
                alu_req.b  = COUNT_W'(eff_attack);
                up_next    = alu_rsp.flag ? upraw_reg[ADDR_W-1:0] : mid_reg;
                a_next     = atk_rd_data;
                state_next = S_RDB;
            end

            S_RDB:
            begin
                atk_rd_en  = 1'b1;
                rd_addr    = up_reg;
                state_next = S_CA;
            end

            S_CA:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = COUNT_W'(out_level_reg);
                alu_req.b  = COUNT_W'(a_reg);
                a_le_next  = !alu_rsp.flag;
                a_lt_next  = !alu_rsp.flag && !alu_zero;
                da_next    = alu_rsp.res[LEVEL_W-1:0];
                state_next = S_CB;
            end

            S_CB:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = COUNT_W'(atk_rd_data);
                alu_req.b  = COUNT_W'(out_level_reg);
                db_next    = alu_rsp.res[LEVEL_W-1:0];
                if (a_le_reg && b_gt)
                begin
                    state_next = S_CD;
                end
                else
                begin
                    if (a_lt_reg)
                        left_next = upraw_reg;
                    else
                        rend_next = LEN_W'(mid_reg);
                    state_next = S_SCHK;
                end
            end

            S_CD:
            begin
                // ties go to the upper entry
                alu_req.op       = ALU_SUB;
                alu_req.a        = COUNT_W'(da_reg);
                alu_req.b        = COUNT_W'(db_reg);
                phase_count_next = alu_rsp.flag ? COUNT_W'(mid_reg) : COUNT_W'(up_reg);
                state_next       = S_DONE;
            end

            S_SCLMP:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = COUNT_W'(left_reg);
                alu_req.b  = COUNT_W'(eff_attack);
                if (!alu_rsp.flag)
                begin
                    state_next = S_SLM1;
                end
                else
                begin
                    phase_count_next = COUNT_W'(left_reg);
                    state_next       = S_DONE;
                end
            end

            S_SLM1:
            begin
                alu_req.op       = ALU_SUB;
                alu_req.a        = COUNT_W'(eff_attack);
                alu_req.b        = COUNT_W'(1);
                phase_count_next = alu_rsp.res[COUNT_W-1:0];
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_level_next   = out_level_reg;
                    res_phase_next   = env_phase_reg;
                    res_killing_next = kill_active_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            env_phase_reg   <= PH_IDLE;
            phase_count_reg <= '0;
            out_level_reg   <= '0;
            kill_active_reg <= 1'b0;
            kill_step_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            env_phase_reg   <= env_phase_next;
            phase_count_reg <= phase_count_next;
            out_level_reg   <= out_level_next;
            kill_active_reg <= kill_active_next;
            kill_step_reg   <= kill_step_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len_reg    <= '0;
            hold_len_reg      <= '0;
            decay_len_reg     <= '0;
            release_len_reg   <= '0;
            sustain_level_reg <= SUSTAIN_RESET;
            kill_recip_reg    <= KILL_RECIP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ATTACK_LEN:  attack_len_reg    <= cfg_data[CFG_LEN_W-1:0];
                CFG_HOLD_LEN:    hold_len_reg      <= cfg_data[HOLD_W-1:0];
                CFG_DECAY_LEN:   decay_len_reg     <= cfg_data[CFG_LEN_W-1:0];
                CFG_RELEASE_LEN: release_len_reg   <= cfg_data[CFG_LEN_W-1:0];
                CFG_SUSTAIN:     sustain_level_reg <= cfg_data[LEVEL_W-1:0];
                CFG_KILL_RECIP:  kill_recip_reg    <= cfg_data[LEVEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        res_level_reg   <= res_level_next;
        res_phase_reg   <= res_phase_next;
        res_killing_reg <= res_killing_next;
        left_reg        <= left_next;
        rend_reg        <= rend_next;
        sum_reg         <= sum_next;
        mid_reg         <= mid_next;
        upraw_reg       <= upraw_next;
        up_reg          <= up_next;
        a_reg           <= a_next;
        da_reg          <= da_next;
        db_reg          <= db_next;
        a_le_reg        <= a_le_next;
        a_lt_reg        <= a_lt_next;
    end

`ifndef SYNTH
    // search bounds never cross
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCHK) |-> (left_reg <= rend_reg))
        else $error("search left bound beyond right bound");

    // midpoint read stays inside the attack curve
    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUP) |-> (LEN_W'(mid_reg) < eff_attack))
        else $error("search midpoint outside attack curve");

    // a new result only comes from the completion step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion step");
`endif

endmodule

FILE: sim/ahdsr_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdsr_result_checker
// Watches the register port and both request/result channels of the envelope
// core. It keeps its own copy of the registers, envelope state and curve
// tables, works out the result of every accepted request, and compares each
// accepted result field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module ahdsr_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ahdsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ahdsr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [ahdsr_pkg::OP_W-1:0]       operation,
    input  logic [ahdsr_pkg::SEL_W-1:0]      table_select,
    input  logic [ahdsr_pkg::IDX_W-1:0]      table_index,
    input  logic [ahdsr_pkg::LEVEL_W-1:0]    table_value,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [ahdsr_pkg::LEVEL_W-1:0]    level,
    input  logic [ahdsr_pkg::PHASE_W-1:0]    phase,
    input  logic                             killing,
    output int                               mismatches,
    output int                               outstanding
);
    import ahdsr_pkg::*;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
        logic               killing;
    } env_result_t;

    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    env_result_t owed_results[$];

    // register copies
    logic [CFG_LEN_W-1:0] atk_len_r;
    logic [HOLD_W-1:0]    hold_len_r;
    logic [CFG_LEN_W-1:0] dec_len_r;
    logic [CFG_LEN_W-1:0] rel_len_r;
    logic [LEVEL_W-1:0]   sustain_r;
    logic [LEVEL_W-1:0]   kill_recip_r;

    // envelope state
    phase_t               env_ph;
    logic [COUNT_W-1:0]   ph_count;
    logic [LEVEL_W-1:0]   env_level;
    logic                 kill_on;
    logic [LEVEL_W-1:0]   kill_dec;

    logic [LEVEL_W-1:0]   atk_curve [TABLE_DEPTH];
    logic [LEVEL_W-1:0]   dec_curve [TABLE_DEPTH];
    logic [LEVEL_W-1:0]   rel_curve [TABLE_DEPTH];

    int                   errs = 0;
    env_result_t          head;
    logic                 field_bad;

    function automatic int curve_len(input logic [CFG_LEN_W-1:0] n);
        return (int'(n) > TABLE_DEPTH) ? TABLE_DEPTH : int'(n);
    endfunction

    function automatic logic [LEVEL_W-1:0] sustain_out();
        return (sustain_r > FULL_LEVEL) ? FULL_LEVEL : sustain_r;
    endfunction

    // Next level from the phase machine; moves to the following phase at the
    // end of the current one.
    function automatic logic [LEVEL_W-1:0] advance_phase();
        case (env_ph)
            PH_ATTACK:
            begin
                if (ph_count >= curve_len(atk_len_r))
                begin
                    env_ph   = PH_HOLD;
                    ph_count = '0;
                    return FULL_LEVEL;
                end
                return atk_curve[ph_count[ADDR_W-1:0]];
            end
            PH_HOLD:
            begin
                if (ph_count >= hold_len_r)
                begin
                    env_ph   = PH_DECAY;
                    ph_count = '0;
                end
                return FULL_LEVEL;
            end
            PH_DECAY:
            begin
                if (ph_count >= curve_len(dec_len_r))
                begin
                    env_ph   = PH_SUSTAIN;
                    ph_count = '0;
                    return sustain_out();
                end
                return dec_curve[ph_count[ADDR_W-1:0]];
            end
            PH_SUSTAIN:
                return sustain_out();
            PH_RELEASE:
            begin
                if (ph_count >= curve_len(rel_len_r))
                begin
                    env_ph   = PH_IDLE;
                    ph_count = '0;
                    return '0;
                end
                return rel_curve[ph_count[ADDR_W-1:0]];
            end
            default:
                return '0;
        endcase
    endfunction

    // Binary search of the attack curve for the position nearest a level.
    function automatic int nearest_attack_pos(input int target);
        int n;
        int lo;
        int hi;
        int mid;
        int up;
        int a;
        int b;
        n = curve_len(atk_len_r);
        if (n == 0)
            return 0;
        lo = 0;
        hi = n - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            up  = (mid + 1 > n - 1) ? n - 1 : mid + 1;
            a   = int'(atk_curve[mid]);
            b   = int'(atk_curve[up]);
            if (a <= target && b > target)
                return ((target - a) < (b - target)) ? mid : up;
            if (a < target)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return (lo > n - 1) ? n - 1 : lo;
    endfunction

    function automatic env_result_t apply_request(input logic [OP_W-1:0]    op,
                                                  input logic [SEL_W-1:0]   sel,
                                                  input logic [IDX_W-1:0]   idx,
                                                  input logic [LEVEL_W-1:0] val);
        logic [PROD_W-1:0]  prod;
        logic [LEVEL_W-1:0] clipped;
        env_result_t        r;
        case (op)
            OP_TICK:
            begin
                if (kill_on)
                begin
                    env_level = (env_level > kill_dec) ? env_level - kill_dec : '0;
                    kill_on   = (env_level != '0);
                end
                else
                    env_level = advance_phase();
                if (ph_count != COUNT_TOP)
                    ph_count = ph_count + 1'b1;
            end
            OP_GATE_ON:
            begin
                env_ph   = PH_ATTACK;
                ph_count = '0;
                kill_on  = 1'b0;
            end
            OP_GATE_OFF:
            begin
                env_ph   = PH_RELEASE;
                ph_count = '0;
            end
            OP_STEAL:
            begin
                env_ph   = PH_ATTACK;
                kill_on  = 1'b0;
                ph_count = COUNT_W'(nearest_attack_pos(int'(env_level)));
            end
            OP_KILL:
            begin
                prod     = env_level * kill_recip_r;
                kill_dec = prod[PROD_W-1:LEVEL_W];
                // a non-zero level always gets a step so the ramp ends
                if (kill_dec == '0 && env_level != '0)
                    kill_dec = LEVEL_W'(1);
                kill_on  = 1'b1;
            end
            OP_LOAD:
            begin
                clipped = (val > FULL_LEVEL) ? FULL_LEVEL : val;
                case (sel)
                    SEL_ATTACK:  atk_curve[idx] = clipped;
                    SEL_DECAY:   dec_curve[idx] = clipped;
                    SEL_RELEASE: rel_curve[idx] = clipped;
                    default:     ;
                endcase
            end
            default:
                ;
        endcase
        r.level   = env_level;
        r.phase   = env_ph;
        r.killing = kill_on;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atk_len_r    = '0;
            hold_len_r   = '0;
            dec_len_r    = '0;
            rel_len_r    = '0;
            sustain_r    = 16'd16384;
            kill_recip_r = 16'd331;
            env_ph       = PH_IDLE;
            ph_count     = '0;
            env_level    = '0;
            kill_on      = 1'b0;
            kill_dec     = '0;
            owed_results.delete();
            outstanding <= 0;
            mismatches  <= errs;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ATTACK_LEN:  atk_len_r    = cfg_data[CFG_LEN_W-1:0];
                    CFG_HOLD_LEN:    hold_len_r   = cfg_data[HOLD_W-1:0];
                    CFG_DECAY_LEN:   dec_len_r    = cfg_data[CFG_LEN_W-1:0];
                    CFG_RELEASE_LEN: rel_len_r    = cfg_data[CFG_LEN_W-1:0];
                    CFG_SUSTAIN:     sustain_r    = cfg_data[LEVEL_W-1:0];
                    CFG_KILL_RECIP:  kill_recip_r = cfg_data[LEVEL_W-1:0];
                    default:         ;
                endcase
            end

            // results first: one accepted now cannot belong to a request
            // accepted at the same edge
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result expected none actual level %0d phase %0d killing %0b",
                             $time, level, phase, killing);
                    errs++;
                end
                else
                begin
                    head      = owed_results.pop_front();
                    field_bad = 1'b0;
                    if (level !== head.level)
                    begin
                        $display("%0t: level expected %0d actual %0d",
                                 $time, head.level, level);
                        field_bad = 1'b1;
                    end
                    if (phase !== head.phase)
                    begin
                        $display("%0t: phase expected %0d actual %0d",
                                 $time, head.phase, phase);
                        field_bad = 1'b1;
                    end
                    if (killing !== head.killing)
                    begin
                        $display("%0t: killing expected %0b actual %0b",
                                 $time, head.killing, killing);
                        field_bad = 1'b1;
                    end
                    if (field_bad)
                        errs++;
                end
            end

            if (in_valid && in_ready)
                owed_results.push_back(apply_request(operation, table_select,
                                                     table_index, table_value));

            outstanding <= owed_results.size();
            mismatches  <= errs;
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the AHDSR envelope core: a short directed run at the reset
// registers, then a series of register settings, each with freshly loaded
// curves and mostly well-formed note sequences mixed with noise, under bursty
// requests and a stalling receiver. Checking is done by the result checker.
// ----------------------------------------------------------------------------
module tb;
    import ahdsr_pkg::*;

    localparam int QUIET_LIMIT       = 4000;
    localparam int ITEMS_PER_SETTING = 50;
    localparam int SETTING_COUNT     = 9;
    // decay/release curves are only loaded this far; a setting with longer
    // curves must tick fewer times than this within the setting
    localparam int CURVE_FILL_CAP    = 240;
    localparam int END_SETTLE        = 150;

    localparam logic [OP_W-1:0]  OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0]  OP_SPARE_7 = 3'd7;
    localparam logic [SEL_W-1:0] SEL_NONE   = 2'd3;

    typedef struct {
        int atk;
        int hold;
        int dec;
        int rel;
        int sus;
        int recip;
    } env_setting_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       operation    = '0;
    logic [SEL_W-1:0]      table_select = '0;
    logic [IDX_W-1:0]      table_index  = '0;
    logic [LEVEL_W-1:0]    table_value  = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [LEVEL_W-1:0]    level;
    logic [PHASE_W-1:0]    phase;
    logic                  killing;

    int mismatches;
    int outstanding;
    int burst_left    = 0;
    int requests_sent = 0;
    int quiet_cycles  = 0;
    int stall_left    = 0;
    int stall_mode    = 0;
    int mode_left     = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    ahdsr_envelope_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .table_select (table_select),
        .table_index  (table_index),
        .table_value  (table_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .level        (level),
        .phase        (phase),
        .killing      (killing)
    );

    ahdsr_result_checker results (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .table_select (table_select),
        .table_index  (table_index),
        .table_value  (table_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .level        (level),
        .phase        (phase),
        .killing      (killing),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // receiver: always ready, random, or occasional long stalls
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 9) < 7);
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left <= $urandom_range(1, 24);
                        out_ready  <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
                end
            endcase
        end
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(50, 300);
        end
        else
            mode_left <= mode_left - 1;
    end

    // watchdog: ends the run after a long stretch with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("ahdsr_envelope_generator_core regression: fail");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [OP_W-1:0]    op,
                                input logic [SEL_W-1:0]   sel,
                                input logic [IDX_W-1:0]   idx,
                                input logic [LEVEL_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 10);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        operation    <= op;
        table_select <= sel;
        table_index  <= idx;
        table_value  <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        requests_sent++;
    endtask

    // fields the operation does not use carry random bits
    task automatic send_op(input logic [OP_W-1:0] op);
        send_request(op, SEL_W'($urandom), IDX_W'($urandom), LEVEL_W'($urandom));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_op(OP_TICK);
    endtask

    task automatic wait_drained();
        in_valid   <= 1'b0;
        burst_left  = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(posedge clk);
    endtask

    task automatic apply_setting(input env_setting_t s);
        wait_drained();
        write_reg(CFG_ATTACK_LEN, s.atk);
        write_reg(CFG_HOLD_LEN, s.hold);
        write_reg(CFG_DECAY_LEN, s.dec);
        write_reg(CFG_RELEASE_LEN, s.rel);
        write_reg(CFG_SUSTAIN, s.sus);
        write_reg(CFG_KILL_RECIP, s.recip);
        cfg_write <= 1'b0;
    endtask

    function automatic env_setting_t pick_setting(input int p);
        env_setting_t s;
        case (p)
            0: s = '{8, 3, 8, 8, 20000, 331};
            1: s = '{1, 0, 1, 1, 0, 65535};
            2: s = '{40, 12, 30, 50, 32768, 1};
            3: s = '{0, 1048575, 0, 0, 65535, 0};
            // decay and release lengths past the table depth; those curves
            // are loaded up to the fill cap
            4: s = '{8, 5, 8191, 8191, 12345, 2000};
            default:
                s = '{$urandom_range(0, 32), $urandom_range(0, 40),
                      $urandom_range(0, 32), $urandom_range(0, 32),
                      $urandom_range(0, 65535), $urandom_range(0, 65535)};
        endcase
        return s;
    endfunction

    function automatic logic [LEVEL_W-1:0] curve_point(input int i, input int n,
                                                       input bit rising);
        int v;
        v = (i * int'(FULL_LEVEL)) / n + $urandom_range(0, int'(FULL_LEVEL) / n);
        if (v > int'(FULL_LEVEL))
            v = int'(FULL_LEVEL);
        return LEVEL_W'(rising ? v : int'(FULL_LEVEL) - v);
    endfunction

    // every entry a setting can read is written before any tick
    task automatic load_curves(input env_setting_t s);
        int n_atk;
        int n_dec;
        int n_rel;
        n_atk = (s.atk > TABLE_DEPTH) ? TABLE_DEPTH : s.atk;
        n_dec = (s.dec > CURVE_FILL_CAP) ? CURVE_FILL_CAP : s.dec;
        n_rel = (s.rel > CURVE_FILL_CAP) ? CURVE_FILL_CAP : s.rel;
        for (int i = 0; i < n_atk; i++)
            send_request(OP_LOAD, SEL_ATTACK, IDX_W'(i), curve_point(i, n_atk, 1'b1));
        for (int i = 0; i < n_dec; i++)
            send_request(OP_LOAD, SEL_DECAY, IDX_W'(i), curve_point(i, n_dec, 1'b0));
        for (int i = 0; i < n_rel; i++)
            send_request(OP_LOAD, SEL_RELEASE, IDX_W'(i), curve_point(i, n_rel, 1'b0));
    endtask

    task automatic run_random(input int target);
        int stop_at;
        int kind;
        stop_at = requests_sent + target;
        while (requests_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // a whole note, sometimes stolen or killed part way
                send_op(OP_GATE_ON);
                send_ticks($urandom_range(0, 80));
                if ($urandom_range(0, 4) == 0)
                begin
                    send_op(($urandom_range(0, 1) == 0) ? OP_KILL : OP_STEAL);
                    send_ticks($urandom_range(0, 20));
                end
                send_op(OP_GATE_OFF);
                send_ticks($urandom_range(0, 70));
            end
            else if (kind < 60)
            begin
                send_op(OP_STEAL);
                send_ticks($urandom_range(0, 30));
            end
            else if (kind < 72)
            begin
                send_op(OP_KILL);
                send_ticks($urandom_range(0, 40));
            end
            else if (kind < 80)
            begin
                send_op(OP_GATE_OFF);
                send_ticks($urandom_range(0, 20));
            end
            else if (kind < 88)
            begin
                repeat ($urandom_range(1, 4))
                    send_request(OP_LOAD, SEL_W'($urandom), IDX_W'($urandom),
                                 LEVEL_W'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_request(OP_W'($urandom), SEL_W'($urandom), IDX_W'($urandom),
                                 LEVEL_W'($urandom));
            end
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        env_setting_t s;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, at reset registers: all curve lengths zero
        send_op(OP_TICK);
        send_op(OP_SPARE_6);
        send_op(OP_SPARE_7);
        send_op(OP_KILL);          // kill at zero level
        send_op(OP_TICK);
        send_op(OP_GATE_OFF);      // release from idle
        send_op(OP_TICK);
        send_op(OP_STEAL);         // steal with no attack curve
        send_ticks(4);             // attack, hold, decay, sustain in turn
        send_op(OP_KILL);
        send_ticks(2);
        send_op(OP_GATE_ON);
        send_op(OP_TICK);
        send_op(OP_KILL);          // kill from full level
        send_op(OP_TICK);
        send_op(OP_STEAL);
        send_request(OP_LOAD, SEL_ATTACK, '0, '0);
        send_request(OP_LOAD, SEL_DECAY, '1, '1);
        send_request(OP_LOAD, SEL_RELEASE, 12'h800, FULL_LEVEL);
        send_request(OP_LOAD, SEL_NONE, '1, 16'h8001);
        send_request(OP_LOAD, SEL_ATTACK, 12'hAAA, 16'h5555);
        send_op(OP_GATE_OFF);
        send_op(OP_TICK);

        for (int p = 0; p < SETTING_COUNT; p++)
        begin
            s = pick_setting(p);
            apply_setting(s);
            load_curves(s);
            run_random(ITEMS_PER_SETTING);
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("ahdsr_envelope_generator_core regression: pass");
        else
            $display("ahdsr_envelope_generator_core regression: fail");
        $finish;
    end

endmodule
